FILE: design/substring_match_positions_core_macros.svh
// assertion macros shared by the design files
`ifndef SUBSTRING_MATCH_POSITIONS_CORE_MACROS_SVH
`define SUBSTRING_MATCH_POSITIONS_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define SMP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define SMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define SMP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SMP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/smp_pkg.sv
package smp_pkg;

	localparam int MAX_PATTERN = 8;
	localparam int MAX_TEXT    = 65536;

	localparam int BYTE_W    = 8;
	localparam int PAT_W     = BYTE_W * MAX_PATTERN;
	localparam int LEN_W     = 4;
	localparam int N_W       = $clog2(MAX_PATTERN + 1);
	localparam int PIDX_W    = (MAX_PATTERN > 2) ? $clog2(MAX_PATTERN) : 1;
	localparam int POS_W     = $clog2(MAX_TEXT + 1);
	localparam int MS_W      = 16;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_NON_OVERLAPPING = CFG_IDX_W'(2);

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

	// pattern length in use: zero counts as one, saturates at the maximum
	function automatic logic [N_W-1:0] active_len(input logic [LEN_W-1:0] len);
		logic [N_W-1:0] n;
		if (len == '0)
			n = N_W'(1);
		else if (32'(len) > MAX_PATTERN)
			n = N_W'(MAX_PATTERN);
		else
			n = N_W'(len);
		return n;
	endfunction

endpackage

FILE: design/smp_cell.sv
module smp_cell
	import smp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctrl_t        ctrl,
	input  logic [BYTE_W-1:0] byte_in,
	input  logic [BYTE_W-1:0] pattern_byte,
	input  logic              active,
	output logic [BYTE_W-1:0] byte_q,
	output logic              match
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctrl.clear) begin
			byte_q <= '0;
		end else if (ctrl.shift) begin
			byte_q <= byte_in;
		end
	end

	// cells beyond the pattern length do not take part
	assign match = !active || (byte_q == pattern_byte);

endmodule

FILE: design/substring_match_positions_core.sv
// Streaming substring search. One text byte is taken per beat, every cycle unless in_stall is high, and the start
// position of each occurrence of the configured pattern (1 to 8 bytes) that ends at that byte
// is registered onto the output. The history sits in a row of byte cells that shift
// once per beat and each compare their byte with one pattern character, so the throughput is
// one byte per cycle while in_stall is low. An output register plus one skid entry
// decouple the sides: input stall rises only once two results are waiting. last_byte ends the
// text and clears the history and the position; bytes past the maximum text length produce
// nothing. Configuration is always ready and should be written while the block is idle.
`include "substring_match_positions_core_macros.svh"

module substring_match_positions_core
	import smp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [BYTE_W-1:0]    text_byte,
	input  logic                 last_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [MS_W-1:0]      match_start,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int NCELL = MAX_PATTERN - 1;

	logic [PAT_W-1:0] pat_q;
	logic [LEN_W-1:0] len_q;
	logic             nonov_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] earliest_q;
	logic             out_valid_q;
	logic [MS_W-1:0]  match_start_q;
	logic             skid_valid_q;
	logic [MS_W-1:0]  skid_q;

	logic              accept;
	logic              out_fire;
	logic [N_W-1:0]    n;
	logic [PIDX_W-1:0] cur_pidx;
	logic              cur_match;
	logic              in_range;
	logic [POS_W-1:0]  pos_p1;
	logic [POS_W-1:0]  start;
	logic              hit;
	logic [MS_W-1:0]   hit_start;
	cell_ctrl_t        cell_ctrl;

	logic [BYTE_W-1:0] hist   [NCELL];
	logic [BYTE_W-1:0] cell_pat [NCELL];
	logic [NCELL-1:0]  cell_active;
	logic [NCELL-1:0]  cell_match;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q   <= '0;
			len_q   <= LEN_W'(1);
			nonov_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PATTERN_BYTES:   pat_q   <= cfg_data[PAT_W-1:0];
				CFG_PATTERN_LENGTH:  len_q   <= cfg_data[LEN_W-1:0];
				CFG_NON_OVERLAPPING: nonov_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign accept   = in_valid && !in_stall;
	assign in_stall = skid_valid_q;
	assign out_fire = out_valid_q && !out_stall;

	assign n         = active_len(len_q);
	assign cur_pidx  = PIDX_W'(n - N_W'(1));
	assign cur_match = (text_byte == pat_q[BYTE_W*cur_pidx +: BYTE_W]);

	// cell j holds the byte j+1 places back and checks pattern character n-2-j
	always_comb begin
		for (int j = 0; j < NCELL; j++) begin
			cell_active[j] = (N_W'(j + 2) <= n);
			cell_pat[j]    = pat_q[BYTE_W*PIDX_W'(n - N_W'(j + 2)) +: BYTE_W];
		end
	end

	assign cell_ctrl.shift = accept && in_range && !last_byte;
	assign cell_ctrl.clear = accept && last_byte;

	for (genvar j = 0; j < NCELL; j++) begin : g_cell
		if (j == 0) begin : g_head
			smp_cell u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.ctrl         (cell_ctrl),
				.byte_in      (text_byte),
				.pattern_byte (cell_pat[j]),
				.active       (cell_active[j]),
				.byte_q       (hist[j]),
				.match        (cell_match[j])
			);
		end else begin : g_body
			smp_cell u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.ctrl         (cell_ctrl),
				.byte_in      (hist[j-1]),
				.pattern_byte (cell_pat[j]),
				.active       (cell_active[j]),
				.byte_q       (hist[j]),
				.match        (cell_match[j])
			);
		end
	end

	assign in_range  = (pos_q < POS_W'(MAX_TEXT));
	assign pos_p1    = pos_q + POS_W'(1);
	assign start     = pos_p1 - POS_W'(n);
	assign hit       = accept && in_range && (pos_p1 >= POS_W'(n)) && cur_match && (&cell_match)
		&& (!nonov_q || (start >= earliest_q));
	assign hit_start = MS_W'(start);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			earliest_q <= '0;
		end else if (accept) begin
			if (last_byte) begin
				pos_q      <= '0;
				earliest_q <= '0;
			end else if (in_range) begin
				pos_q <= pos_p1;
				if (hit)
					earliest_q <= pos_p1;
			end
		end
	end

	// output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			match_start_q <= '0;
			skid_valid_q  <= 1'b0;
			skid_q        <= '0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				match_start_q <= skid_q;
				skid_valid_q  <= 1'b0;
			end
		end else if (hit) begin
			if (!out_valid_q || out_fire) begin
				match_start_q <= hit_start;
				out_valid_q   <= 1'b1;
			end else begin
				skid_q       <= hit_start;
				skid_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign match_start = match_start_q;

	`SMP_ASSERT_IMPL(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	`SMP_ASSERT_NEXT(a_last_clears_pos, clk, arst_n, accept && last_byte, pos_q == '0)
	`SMP_ASSERT_NEXT(a_pos_advances, clk, arst_n, accept && !last_byte && in_range, pos_q == $past(pos_p1))
	`SMP_ASSERT_IMPL(a_earliest_bound, clk, arst_n, 1'b1, earliest_q <= pos_q)

endmodule

FILE: tb/tb_substring_match_positions_core.sv
`timescale 1ns / 1ps

module tb_substring_match_positions_core;
	import smp_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int LONG_HOLD   = 300;

	typedef struct {
		logic [BYTE_W-1:0] ch;
		logic              eot;
	} text_item_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [BYTE_W-1:0]    text_byte = '0;
	logic                 last_byte = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [MS_W-1:0]      match_start;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	// shadow of the search state and registers
	logic [PAT_W-1:0]  cfg_pattern = '0;
	logic [LEN_W-1:0]  cfg_len = LEN_W'(1);
	logic              cfg_nonoverlap = 1'b0;
	logic [BYTE_W-1:0] hist [0:MAX_PATTERN-2];
	logic [POS_W-1:0]  txt_pos = '0;
	logic [POS_W-1:0]  next_free_start = '0;

	text_item_t      pending_bytes [$];
	logic [MS_W-1:0] expected_starts [$];
	logic [MS_W-1:0] want_start;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	logic        hold_request = 1'b0;
	int unsigned hold_cycles = 0;
	int unsigned cycle_count = 0;
	int unsigned errors = 0;
	int unsigned bytes_accepted = 0;
	int unsigned texts_seen = 0;
	int unsigned starts_checked = 0;

	substring_match_positions_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.text_byte  (text_byte),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.match_start(match_start),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int unsigned eff_len();
		if (cfg_len == '0)
			return 1;
		if (cfg_len > MAX_PATTERN)
			return MAX_PATTERN;
		return cfg_len;
	endfunction

	// advance the search by one text byte and queue the start it reports, if any
	function automatic void scan_byte(input logic [BYTE_W-1:0] ch, input logic eot);
		int unsigned n;
		logic [POS_W-1:0] start;
		logic [BYTE_W-1:0] t;
		bit hit;
		if (txt_pos < MAX_TEXT) begin
			n = eff_len();
			if (txt_pos + 1 >= n) begin
				hit = 1'b1;
				for (int i = 0; i < n; i++) begin
					if (i == n - 1)
						t = ch;
					else
						t = hist[n - 2 - i];
					if (t != cfg_pattern[8*i +: 8])
						hit = 1'b0;
				end
				start = POS_W'(txt_pos + 1 - n);
				if (hit && (!cfg_nonoverlap || start >= next_free_start)) begin
					expected_starts.push_back(MS_W'(start));
					next_free_start = txt_pos + 1;
				end
			end
			for (int k = MAX_PATTERN - 2; k > 0; k--)
				hist[k] = hist[k-1];
			hist[0] = ch;
			txt_pos = txt_pos + 1;
		end
		if (eot) begin
			hist = '{default: '0};
			txt_pos = '0;
			next_free_start = '0;
		end
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				scan_byte(text_byte, last_byte);
				bytes_accepted++;
				if (last_byte)
					texts_seen++;
			end
			if (!(in_valid && in_stall)) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid  <= 1'b1;
					text_byte <= pending_bytes[0].ch;
					last_byte <= pending_bytes[0].eot;
					void'(pending_bytes.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				starts_checked++;
				if (expected_starts.size() == 0) begin
					$error("match_start %0d arrived with no match expected", match_start);
					errors++;
				end else begin
					want_start = expected_starts.pop_front();
					if (match_start !== want_start) begin
						$error("match_start mismatch: expected %0d, actual %0d",
							want_start, match_start);
						errors++;
					end
				end
			end
			if (hold_request && hold_cycles < LONG_HOLD) begin
				out_stall <= 1'b1;
				hold_cycles++;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timed out after %0d cycles", cycle_count);
			$display("FAILURE");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_PATTERN_BYTES:   cfg_pattern = val[PAT_W-1:0];
			CFG_PATTERN_LENGTH:  cfg_len = val[LEN_W-1:0];
			CFG_NON_OVERLAPPING: cfg_nonoverlap = val[0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_bytes.size() != 0 || in_valid || expected_starts.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_pace(input int unsigned send_pct, input int unsigned recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	task automatic push_item(input logic [BYTE_W-1:0] ch, input logic eot);
		text_item_t it;
		it.ch  = ch;
		it.eot = eot;
		pending_bytes.push_back(it);
	endtask

	// text built from whole and partial copies of the pattern, or plain noise
	task automatic add_text(input int len, input bit noisy);
		logic [BYTE_W-1:0] body [$];
		int unsigned n;
		int unsigned cut;
		n = eff_len();
		while (body.size() < len) begin
			case ($urandom_range(3))
				0: begin
					for (int i = 0; i < n; i++)
						body.push_back(cfg_pattern[8*i +: 8]);
				end
				1: begin
					cut = $urandom_range(n);
					for (int i = 0; i < cut; i++)
						body.push_back(cfg_pattern[8*i +: 8]);
				end
				2: begin
					body.push_back(cfg_pattern[8*$urandom_range(n - 1) +: 8]);
				end
				default: begin
					body.push_back(BYTE_W'($urandom));
				end
			endcase
		end
		while (body.size() > len)
			void'(body.pop_back());
		foreach (body[i]) begin
			if (noisy)
				push_item(BYTE_W'($urandom), $urandom_range(15) == 0);
			else
				push_item(body[i], i == len - 1);
		end
	endtask

	task automatic random_settings();
		logic [CFG_DAT_W-1:0] pat;
		logic [BYTE_W-1:0] ch_a;
		logic [BYTE_W-1:0] ch_b;
		logic [LEN_W-1:0] len;
		pat = {$urandom, $urandom};
		// two-letter patterns give periodic and self-overlapping cases
		if ($urandom_range(1)) begin
			ch_a = BYTE_W'($urandom);
			ch_b = BYTE_W'($urandom);
			for (int i = 0; i < MAX_PATTERN; i++)
				pat[8*i +: 8] = $urandom_range(1) ? ch_a : ch_b;
		end
		if ($urandom_range(6) == 0)
			len = $urandom_range(1) ? LEN_W'(0) : LEN_W'($urandom_range(9, 15));
		else
			len = LEN_W'($urandom_range(1, MAX_PATTERN));
		write_reg(CFG_PATTERN_BYTES, pat);
		write_reg(CFG_PATTERN_LENGTH, CFG_DAT_W'(len));
		write_reg(CFG_NON_OVERLAPPING, CFG_DAT_W'($urandom_range(1)));
	endtask

	initial begin
		int unsigned phase_items;
		int len;
		hist = '{default: '0};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: zero byte, length one
		set_pace(0, 0);
		push_item(8'h00, 1'b0);
		push_item(8'hFF, 1'b1);
		wait_idle();

		write_reg(CFG_PATTERN_BYTES, 64'h6161);
		write_reg(CFG_PATTERN_LENGTH, 64'd2);
		repeat (3) push_item(8'h61, 1'b0);
		push_item(8'h61, 1'b1);
		wait_idle();
		write_reg(CFG_NON_OVERLAPPING, 64'd1);
		repeat (3) push_item(8'h61, 1'b0);
		push_item(8'h61, 1'b1);
		wait_idle();

		// length zero counts as one, fifteen saturates at eight
		write_reg(CFG_PATTERN_BYTES, '1);
		write_reg(CFG_PATTERN_LENGTH, 64'd0);
		push_item(8'hFF, 1'b0);
		push_item(8'h7F, 1'b1);
		wait_idle();
		write_reg(CFG_PATTERN_LENGTH, 64'd15);
		repeat (7) push_item(8'hFF, 1'b0);
		push_item(8'hFF, 1'b1);
		wait_idle();

		// settings changed mid-text while the sender waits for all results
		write_reg(CFG_PATTERN_BYTES, 64'h6261);
		write_reg(CFG_PATTERN_LENGTH, 64'd2);
		push_item(8'h61, 1'b0);
		push_item(8'h62, 1'b0);
		push_item(8'h61, 1'b0);
		wait_idle();
		write_reg(CFG_PATTERN_LENGTH, 64'd1);
		push_item(8'h62, 1'b0);
		push_item(8'h61, 1'b0);
		push_item(8'h61, 1'b1);
		wait_idle();

		// receiver holds off while every byte matches, so the input backs up
		write_reg(CFG_PATTERN_BYTES, 64'h61);
		write_reg(CFG_NON_OVERLAPPING, 64'd0);
		hold_request = 1'b1;
		repeat (3) begin
			repeat (19) push_item(8'h61, 1'b0);
			push_item(8'h61, 1'b1);
		end
		wait_idle();

		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: set_pace(0, 0);
				1: set_pace(61, 0);
				2: set_pace(0, 61);
				default: set_pace(12, 12);
			endcase
			random_settings();
			phase_items = 0;
			while (phase_items < 180) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
				add_text(len, $urandom_range(4) == 0);
				phase_items += len;
			end
			wait_idle();
		end

		set_pace(0, 0);
		for (int w = 0; w < 20000 && (pending_bytes.size() != 0 || in_valid ||
				expected_starts.size() != 0); w++)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (expected_starts.size() != 0) begin
			$error("%0d expected match starts never arrived", expected_starts.size());
			errors++;
		end
		$display("%0d bytes in %0d texts, %0d match starts checked", bytes_accepted,
			texts_seen, starts_checked);
		$display("both search modes, lengths 0..15, mid-text changes, long output stall");
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+design
design/smp_pkg.sv
design/smp_cell.sv
design/substring_match_positions_core.sv
tb/tb_substring_match_positions_core.sv
